[hw/rtl/bti_pkg.sv]
// ---------------------------------------------------------------------------
// Bilinear table interpolator package
// Shared constants, item codes, sequencer states and a helper function.
// ---------------------------------------------------------------------------
package bti_pkg;

    // Default table dimensions.
    localparam int MaxXPoints = 8;
    localparam int MaxYPoints = 8;

    // Field widths.
    localparam int ValW   = 32;
    localparam int CountW = 4;
    localparam int IdxW   = 3;
    localparam int AccW   = 100;

    // Item kinds.
    typedef enum logic [1:0] {
        KIND_LOAD_X = 2'd0,
        KIND_LOAD_Y = 2'd1,
        KIND_LOAD_Z = 2'd2,
        KIND_EVAL   = 2'd3
    } t_kind;

    // Configuration register indexes.
    localparam logic CFG_X_COUNT = 1'b0;
    localparam logic CFG_Y_COUNT = 1'b1;

    // Sequencer states.
    typedef enum logic [4:0] {
        S_IDLE, S_XRD, S_XCMP, S_YRD, S_YCMP,
        S_FA, S_FB, S_FC, S_FD, S_FE, S_PREP,
        S_M1, S_M2, S_M3, S_M4,
        S_D1, S_D2, S_D3, S_DIV, S_DONE
    } t_state;

    // Magnitude of a 33-bit signed difference; always fits 32 bits here.
    function automatic logic [31:0] mag33(input logic signed [32:0] v);
        logic [32:0] a;
        begin
            a = v[32] ? 33'(-v) : 33'(v);
            return a[31:0];
        end
    endfunction

endpackage

[hw/rtl/bti_if.sv]
// ---------------------------------------------------------------------------
// Bilinear table interpolator channels
// Valid/ready channels for input items and result items.
// ---------------------------------------------------------------------------
interface bti_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [2:0]  x_index;
    logic [2:0]  y_index;
    logic signed [31:0] load_value;
    logic signed [31:0] query_x;
    logic signed [31:0] query_y;

    modport source (output valid, kind, x_index, y_index, load_value, query_x, query_y,
                    input ready);
    modport sink   (input valid, kind, x_index, y_index, load_value, query_x, query_y,
                    output ready);
endinterface

interface bti_out_if;
    logic        valid;
    logic        ready;
    logic signed [31:0] interp_value;
    logic        div_fault;

    modport source (output valid, interp_value, div_fault, input ready);
    modport sink   (input valid, interp_value, div_fault, output ready);
endinterface

[hw/rtl/bilinear_table_interpolator.sv]
// ---------------------------------------------------------------------------
// Bilinear table interpolator
// Breakpoint search and bilinear interpolation over a loaded grid, using
// one shared 32x32 multiplier and a bit-serial divider.
// ---------------------------------------------------------------------------
//  Channel   Dir  Handshake          Contents
//  i_in      in   valid/ready        load or evaluate item
//  o_out     out  valid/ready        interpolated value and fault flag
//  i_cfg_*   in   write enable only  breakpoint counts
//
// A load item is stored as it is accepted and leaves the block idle. An
// evaluate item holds the block busy from its accept cycle through a read
// and a compare state per breakpoint in each axis search, corner fetch and
// setup, four passes on the shared multiplier, the divisor product and the
// bit-serial divider, one quotient bit per cycle. Equal breakpoints end the
// item after setup, and a saturated quotient skips the divider.
// Reset is synchronous; it clears the sequencer and output and sets both counts to 2.
// A finished result waits in the output register; a new item is taken meanwhile.
module bilinear_table_interpolator #(
    parameter int MAX_X_POINTS = bti_pkg::MaxXPoints,
    parameter int MAX_Y_POINTS = bti_pkg::MaxYPoints
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bti_in_if.sink     i_in,
    bti_out_if.source  o_out,
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic [3:0] i_cfg_data
);

    localparam int XW  = $clog2(MAX_X_POINTS);
    localparam int YW  = $clog2(MAX_Y_POINTS);
    localparam int GW  = $clog2(MAX_X_POINTS * MAX_Y_POINTS);
    localparam int XCW = $clog2(MAX_X_POINTS + 1);
    localparam int YCW = $clog2(MAX_Y_POINTS + 1);
    localparam int AW  = bti_pkg::AccW;

    // Storage.
    logic signed [31:0] x_mem [MAX_X_POINTS];
    logic signed [31:0] y_mem [MAX_Y_POINTS];
    logic signed [31:0] z_mem [MAX_X_POINTS * MAX_Y_POINTS];

    bti_pkg::t_state r_state, n_state;
    logic [3:0]  r_xcfg, r_ycfg;
    logic [XCW-1:0] r_nx;
    logic [YCW-1:0] r_ny;
    logic [XW-1:0] r_kx, r_si;
    logic [YW-1:0] r_ky, r_sj;
    logic signed [31:0] r_qx, r_qy, r_x1, r_x2, r_y1, r_y2;
    logic signed [31:0] r_xrd, r_yrd, r_zrd;
    logic signed [31:0] r_z [4];
    logic signed [32:0] r_dx1, r_dx2, r_dy1, r_dy2, r_dxw, r_dyw;
    logic [1:0]  r_t;
    logic        r_tneg, r_neg, r_fault, r_sat;
    logic [63:0] r_prod, r_den;
    logic [31:0] r_phi, r_qsh;
    logic signed [AW-1:0] r_acc;
    logic [AW-1:0] r_num;
    logic [64:0] r_rem;
    logic [4:0]  r_cnt;
    logic        r_out_valid, r_out_fault;
    logic signed [31:0] r_out_val;

    logic [XW-1:0] x_ra;
    logic [YW-1:0] y_ra;
    logic [GW-1:0] g_ra;
    logic [31:0]   mul_a, mul_b;
    logic          in_acc, out_free, ready;
    logic          x_lt, x_last, y_lt, y_last, fault, div_ge;
    logic [64:0]   trial;
    logic signed [32:0] a_sel, b_sel;
    logic signed [31:0] z_sel;
    logic [AW-1:0] addend;
    logic [XCW-1:0] nx_eff;
    logic [YCW-1:0] ny_eff;
    logic signed [31:0] res_val;

    assign in_acc   = i_in.valid && ready;
    assign out_free = !r_out_valid || o_out.ready;
    assign i_in.ready         = ready;
    assign o_out.valid        = r_out_valid;
    assign o_out.interp_value = r_out_val;
    assign o_out.div_fault    = r_out_fault;

    // Effective breakpoint counts, clamped to [2, max].
    always_comb begin
        if (r_xcfg < 4'd2) nx_eff = XCW'(2);
        else if (int'(r_xcfg) > MAX_X_POINTS) nx_eff = XCW'(MAX_X_POINTS);
        else nx_eff = XCW'(r_xcfg);
        if (r_ycfg < 4'd2) ny_eff = YCW'(2);
        else if (int'(r_ycfg) > MAX_Y_POINTS) ny_eff = YCW'(MAX_Y_POINTS);
        else ny_eff = YCW'(r_ycfg);
    end

    // Search compares and datapath helpers.
    assign x_lt   = r_qx < r_xrd;
    assign x_last = (r_kx == XW'(r_nx - XCW'(2)));
    assign y_lt   = r_qy < r_yrd;
    assign y_last = (r_ky == YW'(r_ny - YCW'(2)));
    assign fault  = (r_x1 == r_x2) || (r_y1 == r_y2);
    assign a_sel  = r_t[0] ? r_dx1 : r_dx2;
    assign b_sel  = r_t[1] ? r_dy1 : r_dy2;
    assign z_sel  = r_z[r_t];
    assign addend = (r_state == bti_pkg::S_M3) ? {36'd0, r_prod} : {4'd0, r_prod, 32'd0};
    assign trial  = {r_rem[63:0], r_qsh[31]};
    assign div_ge = trial >= {1'b0, r_den};

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bti_pkg::S_IDLE:
                if (in_acc && i_in.kind == bti_pkg::KIND_EVAL) n_state = bti_pkg::S_XRD;
            bti_pkg::S_XRD:  n_state = bti_pkg::S_XCMP;
            bti_pkg::S_XCMP: n_state = (x_lt || x_last) ? bti_pkg::S_YRD : bti_pkg::S_XRD;
            bti_pkg::S_YRD:  n_state = bti_pkg::S_YCMP;
            bti_pkg::S_YCMP: n_state = (y_lt || y_last) ? bti_pkg::S_FA : bti_pkg::S_YRD;
            bti_pkg::S_FA:   n_state = bti_pkg::S_FB;
            bti_pkg::S_FB:   n_state = bti_pkg::S_FC;
            bti_pkg::S_FC:   n_state = bti_pkg::S_FD;
            bti_pkg::S_FD:   n_state = bti_pkg::S_FE;
            bti_pkg::S_FE:   n_state = bti_pkg::S_PREP;
            bti_pkg::S_PREP: n_state = fault ? bti_pkg::S_DONE : bti_pkg::S_M1;
            bti_pkg::S_M1:   n_state = bti_pkg::S_M2;
            bti_pkg::S_M2:   n_state = bti_pkg::S_M3;
            bti_pkg::S_M3:   n_state = bti_pkg::S_M4;
            bti_pkg::S_M4:   n_state = (r_t == 2'd3) ? bti_pkg::S_D1 : bti_pkg::S_M1;
            bti_pkg::S_D1:   n_state = bti_pkg::S_D2;
            bti_pkg::S_D2:   n_state = bti_pkg::S_D3;
            bti_pkg::S_D3:
                n_state = (r_num[AW-1:32] >= {4'd0, r_den}) ? bti_pkg::S_DONE
                                                            : bti_pkg::S_DIV;
            bti_pkg::S_DIV:  n_state = (r_cnt == 5'd31) ? bti_pkg::S_DONE : bti_pkg::S_DIV;
            bti_pkg::S_DONE: if (out_free) n_state = bti_pkg::S_IDLE;
            default:         n_state = bti_pkg::S_IDLE;
        endcase
    end

    // Sequencer outputs: handshake, read addresses, multiplier operands.
    always_comb begin
        ready = 1'b0;
        x_ra  = r_kx;
        y_ra  = r_ky;
        g_ra  = GW'(int'(r_si) * MAX_Y_POINTS + int'(r_sj));
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            bti_pkg::S_IDLE: ready = 1'b1;
            bti_pkg::S_FA: begin
                x_ra = r_si;
                y_ra = r_sj;
            end
            bti_pkg::S_FB: begin
                x_ra = r_si + XW'(1);
                y_ra = r_sj + YW'(1);
                g_ra = GW'((int'(r_si) + 1) * MAX_Y_POINTS + int'(r_sj));
            end
            bti_pkg::S_FC: g_ra = GW'(int'(r_si) * MAX_Y_POINTS + int'(r_sj) + 1);
            bti_pkg::S_FD: g_ra = GW'((int'(r_si) + 1) * MAX_Y_POINTS + int'(r_sj) + 1);
            bti_pkg::S_M1: begin
                mul_a = bti_pkg::mag33(a_sel);
                mul_b = bti_pkg::mag33(b_sel);
            end
            bti_pkg::S_M2: begin
                mul_a = r_prod[31:0];
                mul_b = bti_pkg::mag33({z_sel[31], z_sel});
            end
            bti_pkg::S_M3: begin
                mul_a = r_phi;
                mul_b = bti_pkg::mag33({z_sel[31], z_sel});
            end
            bti_pkg::S_D1: begin
                mul_a = bti_pkg::mag33(r_dxw);
                mul_b = bti_pkg::mag33(r_dyw);
            end
            default: ;
        endcase
    end

    // Final sign and saturation of the quotient; a fault gives zero.
    always_comb begin
        if (r_fault) res_val = '0;
        else if (r_sat) res_val = r_neg ? 32'sh8000_0000 : 32'sh7fff_ffff;
        else if (!r_neg) res_val = (r_qsh > 32'h7fff_ffff) ? 32'sh7fff_ffff : r_qsh;
        else res_val = (r_qsh > 32'h8000_0000) ? 32'sh8000_0000 : 32'(-r_qsh);
    end

    // Table memories: one write port and one registered read port each.
    always_ff @(posedge i_clk) begin
        if (in_acc && i_in.kind == bti_pkg::KIND_LOAD_X && int'(i_in.x_index) < MAX_X_POINTS)
            x_mem[XW'(i_in.x_index)] <= i_in.load_value;
        if (in_acc && i_in.kind == bti_pkg::KIND_LOAD_Y && int'(i_in.y_index) < MAX_Y_POINTS)
            y_mem[YW'(i_in.y_index)] <= i_in.load_value;
        if (in_acc && i_in.kind == bti_pkg::KIND_LOAD_Z && int'(i_in.x_index) < MAX_X_POINTS
            && int'(i_in.y_index) < MAX_Y_POINTS)
            z_mem[GW'(int'(i_in.x_index) * MAX_Y_POINTS + int'(i_in.y_index))]
                <= i_in.load_value;
        r_xrd <= x_mem[x_ra];
        r_yrd <= y_mem[y_ra];
        r_zrd <= z_mem[g_ra];
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bti_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_xcfg      <= 4'd2;
            r_ycfg      <= 4'd2;
        end else begin
            r_state <= n_state;
            if (i_cfg_we && i_cfg_idx == bti_pkg::CFG_X_COUNT) r_xcfg <= i_cfg_data;
            if (i_cfg_we && i_cfg_idx == bti_pkg::CFG_Y_COUNT) r_ycfg <= i_cfg_data;
            if (r_state == bti_pkg::S_DONE && out_free) r_out_valid <= 1'b1;
            else if (o_out.ready) r_out_valid <= 1'b0;
        end
    end

    // Datapath.
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        case (r_state)
            bti_pkg::S_IDLE: begin
                r_qx <= i_in.query_x;
                r_qy <= i_in.query_y;
                r_nx <= nx_eff;
                r_ny <= ny_eff;
                r_kx <= '0;
                r_ky <= '0;
            end
            bti_pkg::S_XCMP: begin
                if (x_lt) r_si <= (r_kx == '0) ? '0 : r_kx - XW'(1);
                else if (x_last) r_si <= r_kx;
                else r_kx <= r_kx + XW'(1);
            end
            bti_pkg::S_YCMP: begin
                if (y_lt) r_sj <= (r_ky == '0) ? '0 : r_ky - YW'(1);
                else if (y_last) r_sj <= r_ky;
                else r_ky <= r_ky + YW'(1);
            end
            bti_pkg::S_FB: begin
                r_x1   <= r_xrd;
                r_y1   <= r_yrd;
                r_z[0] <= r_zrd;
            end
            bti_pkg::S_FC: begin
                r_x2   <= r_xrd;
                r_y2   <= r_yrd;
                r_z[1] <= r_zrd;
            end
            bti_pkg::S_FD: r_z[2] <= r_zrd;
            bti_pkg::S_FE: r_z[3] <= r_zrd;
            bti_pkg::S_PREP: begin
                r_dx1   <= 33'(r_qx) - 33'(r_x1);
                r_dx2   <= 33'(r_x2) - 33'(r_qx);
                r_dy1   <= 33'(r_qy) - 33'(r_y1);
                r_dy2   <= 33'(r_y2) - 33'(r_qy);
                r_dxw   <= 33'(r_x2) - 33'(r_x1);
                r_dyw   <= 33'(r_y2) - 33'(r_y1);
                r_fault <= fault;
                r_acc   <= '0;
                r_t     <= 2'd0;
            end
            bti_pkg::S_M1: r_tneg <= z_sel[31] ^ a_sel[32] ^ b_sel[32];
            bti_pkg::S_M2: r_phi <= r_prod[63:32];
            bti_pkg::S_M3, bti_pkg::S_M4: begin
                r_acc <= r_tneg ? r_acc - $signed(addend) : r_acc + $signed(addend);
                if (r_state == bti_pkg::S_M4) r_t <= r_t + 2'd1;
            end
            bti_pkg::S_D2: begin
                r_den <= r_prod;
                r_neg <= r_acc[AW-1] ^ (r_dxw[32] != r_dyw[32]);
                r_num <= r_acc[AW-1] ? AW'(-r_acc) : AW'(r_acc);
            end
            bti_pkg::S_D3: begin
                r_sat <= r_num[AW-1:32] >= {4'd0, r_den};
                r_rem <= {1'b0, r_num[95:32]};
                r_qsh <= r_num[31:0];
                r_cnt <= '0;
            end
            bti_pkg::S_DIV: begin
                r_rem <= div_ge ? trial - {1'b0, r_den} : trial;
                r_qsh <= {r_qsh[30:0], div_ge};
                r_cnt <= r_cnt + 5'd1;
            end
            bti_pkg::S_DONE: begin
                if (out_free) begin
                    r_out_val   <= res_val;
                    r_out_fault <= r_fault;
                end
            end
            default: ;
        endcase
    end

endmodule

[hw/rtl/bti_checker.sv]
// ---------------------------------------------------------------------------
// Bilinear table interpolator checker
// Port-level checks on the result channel and the input handshake.
// ---------------------------------------------------------------------------
module bti_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [1:0]  in_kind,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] out_value,
    input logic        out_fault
);

    // A result that is not taken stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result withdrawn before it was taken");

    // Reset empties the output register.
    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !out_valid)
        else $error("result valid right after reset");

    // A fault result always carries zero.
    a_fault_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && out_fault |-> out_value == 32'd0)
        else $error("fault result with nonzero value");

    // An evaluate item keeps the block busy on the following cycle.
    a_eval_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready && in_kind == bti_pkg::KIND_EVAL |=> !in_ready)
        else $error("ready right after an evaluate item");

    // A load item completes at once and leaves the block ready.
    a_load_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready && in_kind != bti_pkg::KIND_EVAL |=> in_ready)
        else $error("not ready after a load item");

endmodule

bind bilinear_table_interpolator bti_checker u_bti_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .in_valid  (i_in.valid),
    .in_ready  (i_in.ready),
    .in_kind   (i_in.kind),
    .out_valid (o_out.valid),
    .out_ready (o_out.ready),
    .out_value (o_out.interp_value),
    .out_fault (o_out.div_fault)
);
